/* hw/rtl/sized_integer_op_evaluator_assert.svh */
// assertion macros for the sized integer operation evaluator
`ifndef SIZED_INTEGER_OP_EVALUATOR_ASSERT_SVH
`define SIZED_INTEGER_OP_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SIOE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sioe assertion failed");
// next-cycle implication
`define SIOE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sioe assertion failed");
`else
`define SIOE_ASSERT_NOW(lbl, ante, cons)
`define SIOE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/sioe_pkg.sv */
// ----------------------------------------------------------------------------
// sioe_pkg
// shared types, operation codes and helpers of the sized integer evaluator
// ----------------------------------------------------------------------------
package sioe_pkg;

	localparam logic [5:0] OP_COPY    = 6'd0;
	localparam logic [5:0] OP_PIECE   = 6'd1;
	localparam logic [5:0] OP_SUBPC   = 6'd2;
	localparam logic [5:0] OP_EQ      = 6'd3;
	localparam logic [5:0] OP_NE      = 6'd4;
	localparam logic [5:0] OP_SLT     = 6'd5;
	localparam logic [5:0] OP_SLE     = 6'd6;
	localparam logic [5:0] OP_LT      = 6'd7;
	localparam logic [5:0] OP_LE      = 6'd8;
	localparam logic [5:0] OP_ZEXT    = 6'd9;
	localparam logic [5:0] OP_SEXT    = 6'd10;
	localparam logic [5:0] OP_ADD     = 6'd11;
	localparam logic [5:0] OP_SUB     = 6'd12;
	localparam logic [5:0] OP_CARRY   = 6'd13;
	localparam logic [5:0] OP_SCARRY  = 6'd14;
	localparam logic [5:0] OP_SBORROW = 6'd15;
	localparam logic [5:0] OP_NEG     = 6'd16;
	localparam logic [5:0] OP_NOT     = 6'd17;
	localparam logic [5:0] OP_XOR     = 6'd18;
	localparam logic [5:0] OP_AND     = 6'd19;
	localparam logic [5:0] OP_OR      = 6'd20;
	localparam logic [5:0] OP_SHL     = 6'd21;
	localparam logic [5:0] OP_SHR     = 6'd22;
	localparam logic [5:0] OP_SAR     = 6'd23;
	localparam logic [5:0] OP_MUL     = 6'd24;
	localparam logic [5:0] OP_DIV     = 6'd25;
	localparam logic [5:0] OP_SDIV    = 6'd26;
	localparam logic [5:0] OP_REM     = 6'd27;
	localparam logic [5:0] OP_SREM    = 6'd28;
	localparam logic [5:0] OP_BNOT    = 6'd29;
	localparam logic [5:0] OP_BXOR    = 6'd30;
	localparam logic [5:0] OP_BAND    = 6'd31;
	localparam logic [5:0] OP_BOR     = 6'd32;
	localparam logic [5:0] OP_PTRADD  = 6'd33;
	localparam logic [5:0] OP_PTRSUB  = 6'd34;
	localparam logic [5:0] OP_POPCNT  = 6'd35;
	localparam logic [5:0] OP_LZCNT   = 6'd36;

	localparam int QDEPTH = 4;

	typedef enum logic [1:0] {CLS_ALU, CLS_MUL, CLS_DIV} cls_t;

	typedef enum logic [1:0] {EX_IDLE, EX_MUL, EX_DIV} ex_state_t;

	typedef struct packed {
		logic [5:0]  action;
		logic [3:0]  si;
		logic [3:0]  so;
		logic [63:0] mi;
		logic [63:0] mo;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		cls_t        cls;
	} entry_t;

	typedef struct packed {
		logic [2:0] count;
	} q_status_t;

	typedef struct packed {
		logic   empty;
		entry_t head;
	} q_head_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		for (int k = 0; k < 8; k++)
			m[8*k +: 8] = (4'(k) < n) ? 8'hff : 8'h00;
		return m;
	endfunction

	// bit 8*n-1 of v, n in 1..8
	function automatic logic sign_at(input logic [63:0] v, input logic [3:0] n);
		logic [2:0] nm1;
		nm1 = 3'(n - 4'd1);
		return v[{nm1, 3'b111}];
	endfunction

endpackage

/* hw/rtl/sized_integer_op_evaluator.sv */
// ----------------------------------------------------------------------------
// sized_integer_op_evaluator
// sized integer alu with flags: intake, request queue and execution back end
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start / busy       action, size_in, size_out, operand_a/b/c
//  result    strobe (no stall)  result, status
//
//  plain alu operations: one request a cycle unless a mul or div holds the back end
//  multiply and pointer add hold the back end for issue plus three 32x32 products
//  divide and remainder hold it for issue plus 64 radix-2 steps; by zero ends at issue
//  results leave in request order, one strobe each, in the cycle after execution
//  busy rises once the queue and the intake stage together hold four requests
//  reset clears control only; no result is pending after reset
`include "sized_integer_op_evaluator_assert.svh"

module sized_integer_op_evaluator import sioe_pkg::*; #(
	parameter int MAX_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [5:0]  action,
	input  logic [3:0]  size_in,
	input  logic [3:0]  size_out,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	input  logic [63:0] operand_c,
	output logic        strobe,
	output logic [63:0] result,
	output logic        status
);

	// front to queue
	logic      push;
	entry_t    push_entry;
	// queue to back and front
	logic      pop;
	q_head_t   qhead;
	q_status_t qstat;

	// intake and classification
	sioe_front #(.MAX_BYTES(MAX_BYTES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.size_in    (size_in),
		.size_out   (size_out),
		.operand_a  (operand_a),
		.operand_b  (operand_b),
		.operand_c  (operand_c),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue
	sioe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.qhead      (qhead),
		.qstat      (qstat)
	);

	// execution
	sioe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qhead  (qhead),
		.pop    (pop),
		.strobe (strobe),
		.result (result),
		.status (status)
	);

	// queue never overfills
	`SIOE_ASSERT_NOW(a_q_bound, push, qstat.count != 3'(QDEPTH) || pop)
	// the back end only takes from a filled queue
	`SIOE_ASSERT_NOW(a_pop_nonempty, pop, !qhead.empty)
	// a divide by zero reports a zero value
	`SIOE_ASSERT_NOW(a_err_zero, strobe && status, result == 64'd0)

endmodule

/* hw/rtl/sioe_front.sv */
// ----------------------------------------------------------------------------
// sioe_front
// request intake: size clamping, masks and operation class
// ----------------------------------------------------------------------------
module sioe_front import sioe_pkg::*; #(
	parameter int MAX_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [5:0]  action,
	input  logic [3:0]  size_in,
	input  logic [3:0]  size_out,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	input  logic [63:0] operand_c,
	input  q_status_t   qstat,
	output logic        push,
	output entry_t      push_entry
);

	logic   valid_s1;
	entry_t entry_s1;
	logic   accept;
	logic [3:0] si, so;
	cls_t   cls;

	function automatic logic [3:0] clamp(input logic [3:0] n);
		if (n == 4'd0) return 4'd1;
		if (n > 4'(MAX_BYTES)) return 4'(MAX_BYTES);
		return n;
	endfunction

	assign busy   = ({1'b0, qstat.count} + {3'b0, valid_s1}) >= 4'(QDEPTH);
	assign accept = start && !busy;
	assign si     = clamp(size_in);
	assign so     = clamp(size_out);

	always_comb begin
		unique case (action)
			OP_MUL, OP_PTRADD: cls = CLS_MUL;
			OP_DIV, OP_SDIV, OP_REM, OP_SREM: cls = CLS_DIV;
			default: cls = CLS_ALU;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1.action <= action;
			entry_s1.si     <= si;
			entry_s1.so     <= so;
			entry_s1.mi     <= byte_mask(si);
			entry_s1.mo     <= byte_mask(so);
			entry_s1.a      <= operand_a;
			entry_s1.b      <= operand_b;
			entry_s1.c      <= operand_c;
			entry_s1.cls    <= cls;
		end
	end

	assign push       = valid_s1;
	assign push_entry = entry_s1;

endmodule

/* hw/rtl/sioe_queue.sv */
// ----------------------------------------------------------------------------
// sioe_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
module sioe_queue import sioe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    push_entry,
	input  logic      pop,
	output q_head_t   qhead,
	output q_status_t qstat
);

	entry_t     mem [QDEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 2'd1;
			if (pop)
				rd_q <= rd_q + 2'd1;
			count_q <= count_q + {2'b0, push} - {2'b0, pop};
		end
	end

	assign qhead.empty = (count_q == 3'd0);
	assign qhead.head  = mem[rd_q];
	assign qstat.count = count_q;

endmodule

/* hw/rtl/sioe_back.sv */
// ----------------------------------------------------------------------------
// sioe_back
// execution: combinational alu, shared 32x32 multiplier, radix-2 divider
// ----------------------------------------------------------------------------
module sioe_back import sioe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  q_head_t     qhead,
	output logic        pop,
	output logic        strobe,
	output logic [63:0] result,
	output logic        status
);

	ex_state_t   state_q, state_nx;
	entry_t      h;
	logic [63:0] alu_r;
	logic [5:0]  cnt_q;

	// multiply registers
	logic [63:0] mx_q, my_q, madd_q, acc_q, mo_q;
	logic [31:0] mul_l, mul_r;
	logic [63:0] prod, acc_nx;

	// divide registers
	logic [63:0] rem_q, quo_q, den_q;
	logic        nn_q, dn_q, sgn_q, isrem_q;
	logic [64:0] part;
	logic        ge;
	logic [63:0] rem_nx, quo_nx, div_fin;

	// divide prep
	logic [63:0] sn, sd, un, ud;
	logic        dsgn, dz;

	logic        fire;
	logic [63:0] fire_val;
	logic        fire_st;

	assign h = qhead.head;

	// alu
	always_comb begin
		logic [5:0]  psh;
		logic        big, s1, s2, ng;
		logic [64:0] sum;
		logic [63:0] dif, v;
		logic [6:0]  lz;
		psh = (h.so > h.si) ? {3'(h.so - h.si), 3'b000} : 6'd0;
		big = h.b >= {57'b0, h.so, 3'b000};
		s1  = sign_at(h.a, h.si);
		s2  = sign_at(h.b, h.si);
		sum = {1'b0, h.a} + {1'b0, h.b};
		dif = h.a - h.b;
		v   = h.a & h.mi;
		lz  = 7'd0;
		for (int i = 0; i < 64; i++)
			if (v[i]) lz = 7'(63 - i);
		ng  = s1;
		case (h.action)
			OP_COPY, OP_ZEXT: alu_r = h.a;
			OP_PIECE:  alu_r = (h.a << psh) | h.b;
			OP_SUBPC:  alu_r = (h.b >= 64'd8) ? 64'd0 : ((h.a >> {h.b[2:0], 3'b000}) & h.mo);
			OP_EQ:     alu_r = {63'b0, h.a == h.b};
			OP_NE:     alu_r = {63'b0, h.a != h.b};
			OP_SLT:    alu_r = {63'b0, (s1 != s2) ? s1 : (h.a < h.b)};
			OP_SLE:    alu_r = {63'b0, (s1 != s2) ? s1 : (h.a <= h.b)};
			OP_LT:     alu_r = {63'b0, h.a < h.b};
			OP_LE:     alu_r = {63'b0, h.a <= h.b};
			OP_SEXT:   alu_r = (s1 ? (v | ~h.mi) : v) & h.mo;
			OP_ADD, OP_PTRSUB: alu_r = sum[63:0] & h.mo;
			OP_SUB:    alu_r = dif & h.mo;
			OP_CARRY:  alu_r = {63'b0, sum[64] || ((sum[63:0] & ~h.mi) != 64'd0)};
			OP_SCARRY: alu_r = {63'b0, (s1 == s2) && (sign_at(sum[63:0], h.si) != s1)};
			OP_SBORROW: alu_r = {63'b0, (s1 != s2) && (sign_at(dif, h.si) != s1)};
			OP_NEG:    alu_r = (-h.a) & h.mi;
			OP_NOT:    alu_r = (~h.a) & h.mi;
			OP_XOR, OP_BXOR: alu_r = h.a ^ h.b;
			OP_AND, OP_BAND: alu_r = h.a & h.b;
			OP_OR, OP_BOR:   alu_r = h.a | h.b;
			OP_SHL:    alu_r = big ? 64'd0 : ((h.a << h.b[5:0]) & h.mo);
			OP_SHR:    alu_r = big ? 64'd0 : ((h.a & h.mo) >> h.b[5:0]);
			OP_SAR: begin
				if (big)
					alu_r = ng ? h.mo : 64'd0;
				else
					alu_r = (h.a >> h.b[5:0]) |
						(ng ? ((h.mi >> h.b[5:0]) ^ h.mi) : 64'd0);
			end
			OP_BNOT:   alu_r = h.a ^ 64'd1;
			OP_POPCNT: alu_r = {57'b0, 7'($countones(h.a))};
			OP_LZCNT:  alu_r = (v == 64'd0) ? {57'b0, h.si, 3'b000}
				: {57'b0, lz - 7'(64 - {h.si, 3'b000})};
			default:   alu_r = 64'd0;
		endcase
	end

	// divide operand preparation
	always_comb begin
		dsgn = (h.action == OP_SDIV) || (h.action == OP_SREM);
		sn   = sign_at(h.a, h.si) ? ((h.a & h.mi) | ~h.mi) : (h.a & h.mi);
		sd   = sign_at(h.b, h.si) ? ((h.b & h.mi) | ~h.mi) : (h.b & h.mi);
		un   = dsgn ? (sn[63] ? -sn : sn) : h.a;
		ud   = dsgn ? (sd[63] ? -sd : sd) : h.b;
		dz   = dsgn ? (sd == 64'd0) : (h.b == 64'd0);
	end

	// multiplier: one 32x32 partial product per cycle
	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    begin mul_l = mx_q[31:0];  mul_r = my_q[31:0];  end
			2'd1:    begin mul_l = mx_q[31:0];  mul_r = my_q[63:32]; end
			default: begin mul_l = mx_q[63:32]; mul_r = my_q[31:0];  end
		endcase
		prod   = {32'b0, mul_l} * {32'b0, mul_r};
		acc_nx = (cnt_q[1:0] == 2'd0) ? prod : (acc_q + {prod[31:0], 32'b0});
	end

	// divider step
	always_comb begin
		logic [63:0] fq, fr;
		part   = {rem_q, quo_q[63]};
		ge     = part >= {1'b0, den_q};
		rem_nx = ge ? 64'(part - {1'b0, den_q}) : part[63:0];
		quo_nx = {quo_q[62:0], ge};
		fq = (sgn_q && (nn_q != dn_q)) ? -quo_nx : quo_nx;
		fr = (sgn_q && nn_q) ? -rem_nx : rem_nx;
		if (isrem_q)
			div_fin = sgn_q ? (fr & mo_q) : rem_nx;
		else
			div_fin = sgn_q ? (fq & mo_q) : quo_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			EX_IDLE: begin
				if (!qhead.empty) begin
					if (h.cls == CLS_MUL)
						state_nx = EX_MUL;
					else if (h.cls == CLS_DIV && !dz)
						state_nx = EX_DIV;
				end
			end
			EX_MUL: if (cnt_q == 6'd2) state_nx = EX_IDLE;
			EX_DIV: if (cnt_q == 6'd63) state_nx = EX_IDLE;
			default: state_nx = EX_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop      = 1'b0;
		fire     = 1'b0;
		fire_val = 64'd0;
		fire_st  = 1'b0;
		unique case (state_q)
			EX_IDLE: begin
				pop = !qhead.empty;
				if (!qhead.empty && h.cls == CLS_ALU) begin
					fire     = 1'b1;
					fire_val = alu_r;
				end else if (!qhead.empty && h.cls == CLS_DIV && dz) begin
					fire    = 1'b1;
					fire_st = 1'b1;
				end
			end
			EX_MUL: if (cnt_q == 6'd2) begin
				fire     = 1'b1;
				fire_val = (acc_nx + madd_q) & mo_q;
			end
			EX_DIV: if (cnt_q == 6'd63) begin
				fire     = 1'b1;
				fire_val = div_fin;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
			cnt_q   <= '0;
			strobe  <= 1'b0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= pop ? 6'd0 : cnt_q + 6'd1;
			strobe  <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result <= fire_val;
			status <= fire_st;
		end
		if (pop) begin
			mo_q    <= h.mo;
			mx_q    <= (h.action == OP_PTRADD) ? h.b : h.a;
			my_q    <= (h.action == OP_PTRADD) ? h.c : h.b;
			madd_q  <= (h.action == OP_PTRADD) ? h.a : 64'd0;
			quo_q   <= un;
			rem_q   <= 64'd0;
			den_q   <= ud;
			nn_q    <= sn[63];
			dn_q    <= sd[63];
			sgn_q   <= dsgn;
			isrem_q <= (h.action == OP_REM) || (h.action == OP_SREM);
		end else if (state_q == EX_MUL) begin
			acc_q <= acc_nx;
		end else if (state_q == EX_DIV) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

endmodule

/* tb/sized_integer_op_evaluator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sized_integer_op_evaluator_test
// drives sized integer requests through the evaluator and compares every
// strobed result and status against a local prediction of each operation
// ----------------------------------------------------------------------------
module sized_integer_op_evaluator_test import sioe_pkg::*;;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [5:0]  action;
	logic [3:0]  size_in;
	logic [3:0]  size_out;
	logic [63:0] operand_a;
	logic [63:0] operand_b;
	logic [63:0] operand_c;
	logic        strobe;
	logic [63:0] result;
	logic        status;

	// expected result and status of each request still in flight, oldest first
	logic [63:0] pending_result[$];
	logic        pending_status[$];
	int          mismatches;
	int          sender_idle_pct;

	sized_integer_op_evaluator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .size_in(size_in), .size_out(size_out),
		.operand_a(operand_a), .operand_b(operand_b), .operand_c(operand_c),
		.strobe(strobe), .result(result), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sizes of 0 act as 1, above 8 act as 8
	function automatic int unsigned fit_size(input logic [3:0] s);
		if (s == 4'd0)
			return 1;
		if (s > 4'd8)
			return 8;
		return s;
	endfunction

	function automatic logic [63:0] low_bytes(input int unsigned n);
		if (n >= 8)
			return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic logic top_bit(input logic [63:0] v, input int unsigned n);
		return v[8 * n - 1];
	endfunction

	function automatic logic [63:0] widen_signed(input logic [63:0] v, input int unsigned n);
		logic [63:0] m;
		m = low_bytes(n);
		return top_bit(v, n) ? ((v & m) | ~m) : (v & m);
	endfunction

	// computes the expected result and status of one request
	task automatic evaluate(input logic [5:0] op, input logic [3:0] szi, input logic [3:0] szo,
			input logic [63:0] a, input logic [63:0] b, input logic [63:0] c,
			output logic [63:0] r, output logic st);
		int unsigned si, so, sh, msb;
		logic [63:0] mi, mo, n, d, un, ud, q, v;
		logic [64:0] wide;
		logic sa, sb, sr, nn, dn;
		si = fit_size(szi);
		so = fit_size(szo);
		mi = low_bytes(si);
		mo = low_bytes(so);
		r = '0;
		st = 1'b0;
		case (op)
			OP_COPY, OP_ZEXT: r = a;
			OP_PIECE: begin
				sh = (so > si) ? 8 * (so - si) : 0;
				r = (a << sh) | b;
			end
			OP_SUBPC: r = (b >= 64'd8) ? '0 : ((a >> (8 * b[2:0])) & mo);
			OP_EQ: r = 64'(a == b);
			OP_NE: r = 64'(a != b);
			OP_SLT, OP_SLE: begin
				sa = top_bit(a, si);
				sb = top_bit(b, si);
				if (sa != sb)
					r = 64'(sa);
				else
					r = (op == OP_SLT) ? 64'(a < b) : 64'(a <= b);
			end
			OP_LT: r = 64'(a < b);
			OP_LE: r = 64'(a <= b);
			OP_SEXT: r = widen_signed(a, si) & mo;
			OP_ADD, OP_PTRSUB: r = (a + b) & mo;
			OP_SUB: r = (a - b) & mo;
			OP_CARRY: begin
				// carry out of bit 63 counts as well as past the operand size
				wide = {1'b0, a} + {1'b0, b};
				r = 64'(wide[64] || (si < 8 && (wide[63:0] >> (8 * si)) != 0));
			end
			OP_SCARRY: begin
				sa = top_bit(a, si);
				sb = top_bit(b, si);
				sr = top_bit(a + b, si);
				r = 64'(sa == sb && sr != sa);
			end
			OP_SBORROW: begin
				sa = top_bit(a, si);
				sb = top_bit(b, si);
				sr = top_bit(a - b, si);
				r = 64'(sa != sb && sr != sa);
			end
			OP_NEG: r = (~a + 64'd1) & mi;
			OP_NOT: r = ~a & mi;
			OP_XOR, OP_BXOR: r = a ^ b;
			OP_AND, OP_BAND: r = a & b;
			OP_OR, OP_BOR: r = a | b;
			OP_SHL: r = (b >= 64'(8 * so)) ? '0 : ((a << b[5:0]) & mo);
			OP_SHR: r = (b >= 64'(8 * so)) ? '0 : ((a & mo) >> b[5:0]);
			OP_SAR: begin
				sa = top_bit(a, si);
				if (b >= 64'(8 * so))
					r = sa ? mo : '0;
				else begin
					r = a >> b[5:0];
					if (sa)
						r = r | ((mi >> b[5:0]) ^ mi);
				end
			end
			OP_MUL: r = (a * b) & mo;
			OP_DIV, OP_REM: begin
				if (b == '0)
					st = 1'b1;
				else
					r = (op == OP_DIV) ? a / b : a % b;
			end
			OP_SDIV, OP_SREM: begin
				n = widen_signed(a, si);
				d = widen_signed(b, si);
				if (d == '0)
					st = 1'b1;
				else begin
					// magnitudes, so minimum over minus one wraps back to minimum
					nn = n[63];
					dn = d[63];
					un = nn ? -n : n;
					ud = dn ? -d : d;
					if (op == OP_SDIV) begin
						q = un / ud;
						r = ((nn != dn) ? -q : q) & mo;
					end else begin
						q = un % ud;
						r = (nn ? -q : q) & mo;
					end
				end
			end
			OP_BNOT: r = a ^ 64'd1;
			OP_PTRADD: r = (a + b * c) & mo;
			OP_POPCNT: r = 64'($countones(a));
			OP_LZCNT: begin
				v = a & mi;
				if (v == '0)
					r = 64'(8 * si);
				else begin
					msb = 0;
					for (int k = 0; k < 64; k++)
						if (v[k])
							msb = k;
					r = 64'(8 * si - msb - 1);
				end
			end
			default: r = '0;
		endcase
	endtask

	// issues one request and records its expected outcome when it is taken
	task automatic send_request(input logic [5:0] op, input logic [3:0] szi,
			input logic [3:0] szo, input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] c);
		logic [63:0] r;
		logic st;
		while ($urandom_range(99) < sender_idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		action <= op;
		size_in <= szi;
		size_out <= szo;
		operand_a <= a;
		operand_b <= b;
		operand_c <= c;
		evaluate(op, szi, szo, a, b, c, r, st);
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_result.push_back(r);
		pending_status.push_back(st);
		@(negedge clk);
		start = 1'b0;
	endtask

	// a 64-bit value whose upper bits are always clear so small sizes stay in range
	function automatic logic [63:0] rand_word(input int unsigned bytes);
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(5))
			0: v = '0;
			1: v = low_bytes(bytes);
			2: v = 64'd1 << (8 * bytes - 1);
			default: v = v & low_bytes(bytes);
		endcase
		return v;
	endfunction

	// checks every strobed result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_result.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h status %b", result, status);
			end else begin
				if (result !== pending_result[0] || status !== pending_status[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%b got %h/%b",
							pending_result[0], pending_status[0], result, status);
				end
				void'(pending_result.pop_front());
				void'(pending_status.pop_front());
			end
		end
	end

	task automatic wait_drained();
		while (pending_result.size() != 0)
			@(negedge clk);
	endtask

	// extremes of each field and every operation code, including one unknown code
	task automatic test_directed();
		logic [63:0] smin;
		for (int op = 0; op < 38; op++)
			send_request(6'(op), 4'd8, 4'd8, '1, 64'd3, 64'd5);
		smin = 64'h8000_0000_0000_0000;
		send_request(OP_SDIV, 4'd8, 4'd8, smin, '1, '0);
		send_request(OP_SREM, 4'd8, 4'd8, smin, '1, '0);
		send_request(OP_SDIV, 4'd1, 4'd1, 64'h80, 64'hff, '0);
		send_request(OP_DIV, 4'd4, 4'd4, 64'd9, '0, '0);
		send_request(OP_SREM, 4'd2, 4'd2, 64'd9, 64'h1_0000, '0);
		send_request(OP_PIECE, 4'd8, 4'd2, 64'hab, 64'hcd, '0);
		send_request(OP_SHL, 4'd2, 4'd2, 64'h1234, 64'd16, '0);
		send_request(OP_SAR, 4'd2, 4'd2, 64'h8000, 64'd40, '0);
		send_request(OP_SUBPC, 4'd8, 4'd8, '1, 64'd8, '0);
		send_request(OP_CARRY, 4'd8, 4'd8, '1, 64'd1, '0);
		send_request(OP_LZCNT, 4'd0, 4'd15, 64'hff00, '0, '0);
		send_request(OP_ADD, 4'd15, 4'd0, '1, '1, '1);
		wait_drained();
	endtask

	// random requests with a given sender idling rate
	task automatic test_random(input int count, input int idle_pct);
		int unsigned si;
		logic [5:0] op;
		logic [3:0] szi, szo;
		sender_idle_pct = idle_pct;
		for (int k = 0; k < count; k++) begin
			// mostly known codes, some unknown ones and out-of-range sizes
			op = ($urandom_range(19) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(36));
			szi = ($urandom_range(15) == 0) ? 4'($urandom) : 4'($urandom_range(8, 1));
			szo = ($urandom_range(15) == 0) ? 4'($urandom) : 4'($urandom_range(8, 1));
			si = fit_size(szi);
			send_request(op, szi, szo, rand_word(si), ($urandom_range(3) == 0)
				? 64'($urandom_range(70)) : rand_word(si), rand_word(si));
			// hold back once until the block has emptied
			if (k == count / 2)
				wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		int guard;
		mismatches = 0;
		sender_idle_pct = 0;
		start = 1'b0;
		action = '0;
		size_in = 4'd1;
		size_out = 4'd1;
		operand_a = '0;
		operand_b = '0;
		operand_c = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(600, 0);
		test_random(500, 69);
		test_random(400, 6);
		test_random(300, 0);
		guard = 0;
		while (pending_result.size() != 0 && guard < 1000) begin
			@(negedge clk);
			guard++;
		end
		repeat (100) @(negedge clk);
		if (mismatches == 0 && pending_result.size() == 0)
			$display("PASS sized_integer_op_evaluator");
		else
			$display("FAIL sized_integer_op_evaluator");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL sized_integer_op_evaluator");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/sioe_pkg.sv
hw/rtl/sioe_front.sv
hw/rtl/sioe_queue.sv
hw/rtl/sioe_back.sv
hw/rtl/sized_integer_op_evaluator.sv
tb/sized_integer_op_evaluator_test.sv
